// ===== rtl/slcp_pkg.sv =====
// ----------------------------------------------------------------------------
// slcp_pkg
// Types, codes and constants shared by the command line parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package slcp_pkg;

  localparam int STD_ID_DIGITS  = 3;
  localparam int EXT_ID_DIGITS  = 8;
  localparam int MAX_DATA_BYTES = 8;

  localparam int POS_W = 5;
  typedef logic [POS_W-1:0] pos_t;
  localparam pos_t POS_MAX = '1;

  localparam logic [7:0] BITRATE_COUNT_RESET = 8'd9;

  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_ZERO    = 8'h30;

  localparam logic [7:0] CMD_OPEN      = 8'h4F; // O
  localparam logic [7:0] CMD_CLOSE     = 8'h43; // C
  localparam logic [7:0] CMD_VERSION   = 8'h56; // V
  localparam logic [7:0] CMD_ERRREPORT = 8'h45; // E
  localparam logic [7:0] CMD_BITRATE   = 8'h53; // S
  localparam logic [7:0] CMD_SILENT_U  = 8'h4D; // M
  localparam logic [7:0] CMD_SILENT_L  = 8'h6D; // m
  localparam logic [7:0] CMD_RETRY_U   = 8'h41; // A
  localparam logic [7:0] CMD_RETRY_L   = 8'h61; // a
  localparam logic [7:0] CMD_TX_STD    = 8'h74; // t
  localparam logic [7:0] CMD_TX_EXT    = 8'h54; // T
  localparam logic [7:0] CMD_RTR_STD   = 8'h72; // r
  localparam logic [7:0] CMD_RTR_EXT   = 8'h52; // R

  typedef enum logic [3:0] {
    ACT_ERROR     = 4'd0,
    ACT_OPEN      = 4'd1,
    ACT_CLOSE     = 4'd2,
    ACT_BITRATE   = 4'd3,
    ACT_SILENT    = 4'd4,
    ACT_AUTORETRY = 4'd5,
    ACT_VERSION   = 4'd6,
    ACT_ERRREPORT = 4'd7,
    ACT_TRANSMIT  = 4'd8
  } action_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  setting_value;
    logic        extended_id;
    logic        remote_frame;
    logic [31:0] identifier;
    logic [3:0]  length_code;
    logic [63:0] payload;
  } out_item_t;

  // classified character handed from front to back
  typedef struct packed {
    pos_t       pos;
    logic [7:0] cmd;
    logic [7:0] digit;
    logic       eol;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/slcp_front.sv =====
// ----------------------------------------------------------------------------
// slcp_front
// Accepts characters, tracks line position and command, converts digits.
// ----------------------------------------------------------------------------
`default_nettype none

module slcp_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire slcp_pkg::in_item_t in_item,
  input  wire logic              full,
  output logic                   in_stall,
  output logic                   push,
  output slcp_pkg::entry_t       entry
);

  slcp_pkg::pos_t position;
  logic [7:0]     command_char;
  logic [7:0]     c;
  logic [7:0]     digit;

  assign in_stall = full;
  assign push     = in_valid && !full;
  assign c        = in_item.char_in;

  always_comb begin
    if (c >= slcp_pkg::CH_LOWER_A) begin
      digit = c - slcp_pkg::CH_LOWER_A + 8'd10;
    end else if (c >= slcp_pkg::CH_UPPER_A) begin
      digit = c - slcp_pkg::CH_UPPER_A + 8'd10;
    end else begin
      digit = c - slcp_pkg::CH_ZERO;
    end
  end

  assign entry.pos   = position;
  assign entry.cmd   = (position == '0) ? c : command_char;
  assign entry.digit = digit;
  assign entry.eol   = in_item.end_of_line;

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= '0;
      command_char <= '0;
    end else if (push) begin
      if (in_item.end_of_line) begin
        position <= '0;
      end else if (position != slcp_pkg::POS_MAX) begin
        position <= position + slcp_pkg::pos_t'(1);
      end
      if (position == '0) begin
        command_char <= c;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/slcp_queue.sv =====
// ----------------------------------------------------------------------------
// slcp_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module slcp_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire slcp_pkg::entry_t wr_entry,
  input  wire logic             pop,
  output logic                  full,
  output logic                  not_empty,
  output slcp_pkg::entry_t      rd_entry
);

  slcp_pkg::entry_t slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign rd_entry  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/slcp_back.sv =====
// ----------------------------------------------------------------------------
// slcp_back
// Accumulates fields of the line and registers one result at end of line.
// ----------------------------------------------------------------------------
`default_nettype none

module slcp_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  wire slcp_pkg::entry_t q_entry,
  output logic                  pop,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [7:0]       cfg_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output slcp_pkg::out_item_t   out_item
);

  logic [7:0]  bitrate_count;
  logic [7:0]  argument_digit, argument_digit_next;
  logic [31:0] id_accumulator, id_accumulator_next;
  logic [7:0]  dlc_value, dlc_value_next;
  logic [7:0]  high_nibble_hold, high_nibble_hold_next;
  logic [63:0] data_bytes, data_bytes_next;
  logic        bad_line, bad_line_next;
  slcp_pkg::out_item_t result;

  assign cfg_ready = 1'b1;
  assign pop       = q_valid && (!q_entry.eol || !out_valid || !out_stall);

  always_comb begin
    slcp_pkg::pos_t             p;
    logic [7:0]                 cmd;
    logic [7:0]                 d;
    logic                       is_tx;
    logic                       is_ext;
    logic                       is_rtr;
    slcp_pkg::pos_t             idl;
    slcp_pkg::pos_t             off;
    logic [slcp_pkg::POS_W-2:0] k;
    logic [7:0]                 b;
    logic [8:0]                 count;
    logic [8:0]                 need;
    p      = q_entry.pos;
    cmd    = q_entry.cmd;
    d      = q_entry.digit;
    is_ext = (cmd == slcp_pkg::CMD_TX_EXT) || (cmd == slcp_pkg::CMD_RTR_EXT);
    is_rtr = (cmd == slcp_pkg::CMD_RTR_STD) || (cmd == slcp_pkg::CMD_RTR_EXT);
    is_tx  = is_ext || is_rtr || (cmd == slcp_pkg::CMD_TX_STD);
    idl    = is_ext ? slcp_pkg::pos_t'(slcp_pkg::EXT_ID_DIGITS)
                    : slcp_pkg::pos_t'(slcp_pkg::STD_ID_DIGITS);
    off    = p - idl - slcp_pkg::pos_t'(2);
    k      = off[slcp_pkg::POS_W-1:1];
    b      = {high_nibble_hold[3:0], 4'b0} + d;

    argument_digit_next   = argument_digit;
    id_accumulator_next   = id_accumulator;
    dlc_value_next        = dlc_value;
    high_nibble_hold_next = high_nibble_hold;
    data_bytes_next       = data_bytes;
    bad_line_next         = bad_line;

    if (p != '0) begin
      if (p == slcp_pkg::pos_t'(1)) begin
        argument_digit_next = d;
      end
      if (is_tx) begin
        if (p <= idl) begin
          id_accumulator_next = {id_accumulator[27:0], 4'b0} + 32'(d);
        end else if (p == idl + slcp_pkg::pos_t'(1)) begin
          dlc_value_next = d;
          if (d > 8'(slcp_pkg::MAX_DATA_BYTES)) begin
            bad_line_next = 1'b1;
          end
        end else if (!bad_line && (8'(k) < dlc_value)) begin
          if (!off[0]) begin
            high_nibble_hold_next = d;
          end else begin
            for (int i = 0; i < slcp_pkg::MAX_DATA_BYTES; i++) begin
              if (8'(k) == 8'(i)) begin
                data_bytes_next[8*i +: 8] = data_bytes[8*i +: 8] | b;
              end
            end
          end
        end
      end
    end

    count  = 9'(p) + 9'd1;
    need   = 9'(idl) + 9'd2 + {dlc_value_next, 1'b0};
    result = '0;
    unique case (cmd) inside
      slcp_pkg::CMD_OPEN:      result.action = slcp_pkg::ACT_OPEN;
      slcp_pkg::CMD_CLOSE:     result.action = slcp_pkg::ACT_CLOSE;
      slcp_pkg::CMD_VERSION:   result.action = slcp_pkg::ACT_VERSION;
      slcp_pkg::CMD_ERRREPORT: result.action = slcp_pkg::ACT_ERRREPORT;
      slcp_pkg::CMD_BITRATE: begin
        if (p != '0 && argument_digit_next < bitrate_count) begin
          result.action        = slcp_pkg::ACT_BITRATE;
          result.setting_value = argument_digit_next;
        end
      end
      slcp_pkg::CMD_SILENT_U, slcp_pkg::CMD_SILENT_L: begin
        if (p != '0) begin
          result.action        = slcp_pkg::ACT_SILENT;
          result.setting_value = 8'(argument_digit_next == 8'd1);
        end
      end
      slcp_pkg::CMD_RETRY_U, slcp_pkg::CMD_RETRY_L: begin
        if (p != '0) begin
          result.action        = slcp_pkg::ACT_AUTORETRY;
          result.setting_value = 8'(argument_digit_next == 8'd1);
        end
      end
      slcp_pkg::CMD_TX_STD, slcp_pkg::CMD_TX_EXT,
      slcp_pkg::CMD_RTR_STD, slcp_pkg::CMD_RTR_EXT: begin
        if (!bad_line_next && count >= need) begin
          result.action       = slcp_pkg::ACT_TRANSMIT;
          result.extended_id  = is_ext;
          result.remote_frame = is_rtr;
          result.identifier   = id_accumulator_next;
          result.length_code  = dlc_value_next[3:0];
          result.payload      = data_bytes_next;
        end
      end
      default: result.action = slcp_pkg::ACT_ERROR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bitrate_count <= slcp_pkg::BITRATE_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      bitrate_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      argument_digit   <= '0;
      id_accumulator   <= '0;
      dlc_value        <= '0;
      high_nibble_hold <= '0;
      data_bytes       <= '0;
      bad_line         <= 1'b0;
    end else if (pop) begin
      if (q_entry.eol) begin
        argument_digit   <= '0;
        id_accumulator   <= '0;
        dlc_value        <= '0;
        high_nibble_hold <= '0;
        data_bytes       <= '0;
        bad_line         <= 1'b0;
      end else begin
        argument_digit   <= argument_digit_next;
        id_accumulator   <= id_accumulator_next;
        dlc_value        <= dlc_value_next;
        high_nibble_hold <= high_nibble_hold_next;
        data_bytes       <= data_bytes_next;
        bad_line         <= bad_line_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && q_entry.eol) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_entry.eol) begin
      out_item <= result;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/slcan_command_line_parser.sv =====
// ----------------------------------------------------------------------------
// slcan_command_line_parser
// ASCII command line parser: one character per item, one result per line.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | content
//  in      | in  | in_valid/in_stall  | in_item: char_in, end_of_line
//  out     | out | out_valid/out_stall| out_item: action and frame fields
//  cfg     | in  | cfg_valid/cfg_ready| cfg_data: bitrate_count
//
//  One character per cycle sustained while in_stall is low. The end-of-line
//  character passes the queue, then the result is registered at the output.
//  The two-entry queue decouples the front from the accumulate/decode back.
//  in_stall rises only while the queue is full; a stalled result holds the
//  back only on the next end-of-line character. Reset is synchronous and
//  sets bitrate_count to 9 and clears all line state.
// ----------------------------------------------------------------------------
`default_nettype none

module slcan_command_line_parser (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire slcp_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output slcp_pkg::out_item_t      out_item,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [7:0]          cfg_data
);

  logic             push;
  logic             pop;
  logic             full;
  logic             not_empty;
  slcp_pkg::entry_t wr_entry;
  slcp_pkg::entry_t rd_entry;

  slcp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_item  (in_item),
    .full     (full),
    .in_stall (in_stall),
    .push     (push),
    .entry    (wr_entry)
  );

  slcp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_entry  (wr_entry),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .rd_entry  (rd_entry)
  );

  slcp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (not_empty),
    .q_entry   (rd_entry),
    .pop       (pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  a_dlc_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.action == slcp_pkg::ACT_TRANSMIT
    |-> out_item.length_code <= 4'(slcp_pkg::MAX_DATA_BYTES))
    else $error("transmit result with length code out of range");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.action == slcp_pkg::ACT_ERROR
    |-> out_item.setting_value == '0 && out_item.identifier == '0 &&
        out_item.payload == '0 && out_item.length_code == '0)
    else $error("error result carries nonzero fields");

  a_non_tx_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.action != slcp_pkg::ACT_TRANSMIT
    |-> !out_item.extended_id && !out_item.remote_frame &&
        out_item.identifier == '0 && out_item.payload == '0)
    else $error("frame fields set on non-transmit result");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("queue written while full");

endmodule

`default_nettype wire
